// ===== hdl/bgcd_pkg.sv =====
// bgcd_pkg: word widths, datapath command codes and status record for the
// binary GCD core. No dependencies; imported by every module under hdl/.
`default_nettype none

package bgcd_pkg;

  localparam int WORD_WIDTH = 64;                 // working width, 8..64
  localparam int DATA_W     = 64;                 // port width of the fields
  localparam int CNT_W      = $clog2(WORD_WIDTH); // common power-of-two count

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_W-1:0]     data_t;

  // one operation of the shared unit per cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,        // capture both operands, clear the count
    OP_MERGE,       // y <= x | y (zero operand case)
    OP_HALVE_BOTH,  // strip one common factor of two
    OP_MAKE_ODD,    // shift right whichever operand is even
    OP_REDUCE,      // swap if x < y, else x <= x - y
    OP_DOUBLE       // y <= y << 1, count down
  } op_t;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_odd;
    logic y_odd;
    logic x_lt_y;
    logic x_eq_y;
    logic k_zero;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/bgcd_unit.sv =====
// bgcd_unit: operand registers, power-of-two count and the shared
// subtract/compare and one-bit shift unit. Depends on bgcd_pkg.
`default_nettype none

module bgcd_unit (
  input  wire logic            clk,
  input  wire bgcd_pkg::op_t   op,
  input  wire bgcd_pkg::data_t operand_a,
  input  wire bgcd_pkg::data_t operand_b,
  output bgcd_pkg::status_t    status,
  output bgcd_pkg::word_t      result
);
  import bgcd_pkg::*;

  word_t                 x_r, x_nxt;
  word_t                 y_r, y_nxt;
  cnt_t                  k_r, k_nxt;
  logic [WORD_WIDTH:0]   diff;

  // single subtractor: borrow gives the compare, zero gives equality
  assign diff = {1'b0, x_r} - {1'b0, y_r};

  always_comb begin
    status.x_zero = (x_r == '0);
    status.y_zero = (y_r == '0);
    status.x_odd  = x_r[0];
    status.y_odd  = y_r[0];
    status.x_lt_y = diff[WORD_WIDTH];
    status.x_eq_y = (diff == '0);
    status.k_zero = (k_r == '0);
  end

  assign result = y_r;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    k_nxt = k_r;
    case (op)
      OP_LOAD: begin
        x_nxt = operand_a[WORD_WIDTH-1:0];
        y_nxt = operand_b[WORD_WIDTH-1:0];
        k_nxt = '0;
      end
      OP_MERGE: begin
        y_nxt = x_r | y_r;
      end
      OP_HALVE_BOTH: begin
        x_nxt = x_r >> 1;
        y_nxt = y_r >> 1;
        k_nxt = k_r + 1'b1;
      end
      OP_MAKE_ODD: begin
        if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end
        if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end
      end
      OP_REDUCE: begin
        if (diff[WORD_WIDTH]) begin
          x_nxt = y_r;
          y_nxt = x_r;
        end else begin
          x_nxt = diff[WORD_WIDTH-1:0];
        end
      end
      OP_DOUBLE: begin
        y_nxt = y_r << 1;
        k_nxt = k_r - 1'b1;
      end
      default: begin
        x_nxt = x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    k_r <= k_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/binary_gcd_core.sv =====
// binary_gcd_core: top level; sequencer driving bgcd_unit and the result
// register. Depends on bgcd_pkg and bgcd_unit.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   input   | in_valid, in_ready, in_operand_a/_b    | in
//   result  | out_valid, out_ready, out_divisor      | out
//
// One transfer in, one transfer out. After the input transfer the sequencer
// strips each common factor of two (or merges the operands if one is zero),
// strips other zero bits, subtracts and swaps until the operands are equal,
// restores each factor of two, then loads the result register and raises
// out_valid. in_ready is high only in the idle state, from the cycle after
// the result register loads; a new transfer gets in while out_divisor waits,
// and its own result holds in S_RESTORE until that one is taken. Synchronous
// active-low reset on rst_n.
`default_nettype none

module binary_gcd_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bgcd_pkg::data_t in_operand_a,
  input  wire bgcd_pkg::data_t in_operand_b,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bgcd_pkg::data_t      out_divisor
);
  import bgcd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_REDUCE,
    S_RESTORE
  } state_t;

  state_t    state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;
  data_t     divisor_r, divisor_nxt;
  op_t       op;
  status_t   status;
  word_t     result;
  logic      in_xfer;

  bgcd_unit u_unit (
    .clk       (clk),
    .op        (op),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .status    (status),
    .result    (result)
  );

  assign in_ready    = (state_r == S_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_divisor = divisor_r;

  always_comb begin
    state_nxt     = state_r;
    op            = OP_HOLD;
    divisor_nxt   = divisor_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op        = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.x_zero || status.y_zero) begin
          op        = OP_MERGE;
          state_nxt = S_RESTORE;
        end else if (!status.x_odd && !status.y_odd) begin
          op = OP_HALVE_BOTH;
        end else begin
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (!status.x_odd || !status.y_odd) begin
          op = OP_MAKE_ODD;
        end else if (status.x_eq_y) begin
          state_nxt = S_RESTORE;
        end else begin
          op = OP_REDUCE;
        end
      end
      S_RESTORE: begin
        if (!status.k_zero) begin
          op = OP_DOUBLE;
        end else if (!out_valid_r || out_ready) begin
          divisor_nxt   = DATA_W'(result);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    divisor_r <= divisor_nxt;
  end

endmodule

`default_nettype wire
